FILE: design/esft_pkg.sv
// Shared constants, codes and types of the event subscription filter table.
package esft_pkg;

	localparam int SLOTS       = 32;
	localparam int MAX_RESULTS = 32;
	localparam int SlotIdxW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SlotCntW    = $clog2(SLOTS + 1);
	localparam int ResCntW     = $clog2(MAX_RESULTS + 1);

	localparam logic [31:0] ALL_KINDS = 32'hFFFF_FFFF;
	localparam logic [31:0] ID_START  = 32'd1;

	localparam logic [1:0] OP_SUBSCRIBE   = 2'd0;
	localparam logic [1:0] OP_UNSUBSCRIBE = 2'd1;
	localparam logic [1:0] OP_EVENT       = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SUB,
		S_SCAN
	} state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] client_key;
		logic [31:0] filter_kind_mask;
		logic [7:0]  filter_sev_floor;
		logic [31:0] filter_source;
		logic [31:0] target_id;
		logic [4:0]  event_kind;
		logic [7:0]  event_severity;
		logic [31:0] event_source;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_id;
		logic [31:0] match_client;
		logic        matched;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] client;
		logic [31:0] kind_mask;
		logic [7:0]  sev_floor;
		logic [31:0] source;
	} slot_entry_t;

	typedef struct packed {
		logic                wr_en;
		logic [SlotIdxW-1:0] wr_idx;
		slot_entry_t         wr_data;
		logic                rd_en;
		logic [SlotIdxW-1:0] rd_idx;
		logic                clr_en;
		logic [SlotIdxW-1:0] clr_idx;
	} store_ctl_t;

endpackage

FILE: design/esft_if.sv
// Valid/ready channel interfaces for command and result items.
interface esft_cmd_if;
	logic          valid;
	logic          ready;
	esft_pkg::cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface esft_res_if;
	logic          valid;
	logic          ready;
	esft_pkg::res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: design/esft_slot_store.sv
// Slot memory with registered read, slot valid bits and lowest-free-slot encoder.
module esft_slot_store (
	input  logic                              clk,
	input  logic                              arst_n,
	input  esft_pkg::store_ctl_t              ctl,
	output esft_pkg::slot_entry_t             rd_entry,
	output logic                              rd_valid,
	output logic                              free_any,
	output logic [esft_pkg::SlotIdxW-1:0]     free_idx
);

	logic [esft_pkg::SLOTS-1:0] valid_q;
	esft_pkg::slot_entry_t      mem_q [esft_pkg::SLOTS];
	esft_pkg::slot_entry_t      rd_entry_q;
	logic                       rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[ctl.wr_idx] <= 1'b1;
			end
			if (ctl.clr_en) begin
				valid_q[ctl.clr_idx] <= 1'b0;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[ctl.rd_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[ctl.wr_idx] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rd_entry_q <= mem_q[ctl.rd_idx];
		end
	end

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = esft_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = esft_pkg::SlotIdxW'(i);
			end
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_valid = rd_valid_q;

endmodule

FILE: design/event_subscription_filter_table_top.sv
// Event subscription filter table: one command item at a time, slot scan in memory.
// Subscribe: the result item is loaded from the S_SUB state once the result register is free.
// Unsubscribe and event: one slot read per cycle from the single slot memory read port,
// except while result items are stalled; a scan covers up to SLOTS slots (SLOTS = 32).
// A new item is accepted only in idle; ignored opcode: no result.
// Reset clears all slot valid bits and sets the id counter to one; no clearing pass.
module event_subscription_filter_table_top (
	input  logic           clk,
	input  logic           arst_n,
	esft_cmd_if.sink       cmd,
	esft_res_if.source     res
);

	esft_pkg::state_t      state_q, state_d;
	esft_pkg::cmd_t        cmd_q;
	esft_pkg::store_ctl_t  ctl;
	esft_pkg::slot_entry_t rd_entry;
	logic                  rd_valid;
	logic                  free_any;
	logic [esft_pkg::SlotIdxW-1:0] free_idx;

	logic [esft_pkg::SlotCntW-1:0] rd_idx_q, rd_idx_d;
	logic [esft_pkg::SlotIdxW-1:0] idx_s1;
	logic                          v_s1, v_s1_d;
	logic                          hold_v_q, hold_v_d;
	logic [31:0]                   hold_id_q, hold_id_d;
	logic [31:0]                   hold_client_q, hold_client_d;
	logic [esft_pkg::ResCntW-1:0]  n_q, n_d;
	logic [31:0]                   next_id_q, next_id_d;
	logic                          out_v_q;
	esft_pkg::res_t                out_q, out_d;
	logic                          out_load;
	logic                          out_free;

	logic is_event, cap, issue_done, live, hit, pass;
	logic kind_ok, sev_ok, src_ok;

	esft_slot_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rd_entry (rd_entry),
		.rd_valid (rd_valid),
		.free_any (free_any),
		.free_idx (free_idx)
	);

	assign cmd.ready   = (state_q == esft_pkg::S_IDLE);
	assign res.valid   = out_v_q;
	assign res.payload = out_q;
	assign out_free    = !out_v_q || res.ready;

	assign is_event   = (cmd_q.opcode == esft_pkg::OP_EVENT);
	assign cap        = is_event && (n_q == esft_pkg::ResCntW'(esft_pkg::MAX_RESULTS));
	assign issue_done = (rd_idx_q == esft_pkg::SlotCntW'(esft_pkg::SLOTS)) || cap;
	assign live       = v_s1 && rd_valid;
	assign hit        = live && (rd_entry.id == cmd_q.target_id);
	assign kind_ok    = rd_entry.kind_mask[cmd_q.event_kind] ||
		(rd_entry.kind_mask == esft_pkg::ALL_KINDS);
	assign sev_ok     = (cmd_q.event_severity >= rd_entry.sev_floor);
	assign src_ok     = (rd_entry.source == 32'd0) || (rd_entry.source == cmd_q.event_source);
	assign pass       = live && !cap && kind_ok && sev_ok && src_ok;

	always_comb begin
		state_d       = state_q;
		rd_idx_d      = rd_idx_q;
		v_s1_d        = v_s1;
		hold_v_d      = hold_v_q;
		hold_id_d     = hold_id_q;
		hold_client_d = hold_client_q;
		n_d           = n_q;
		next_id_d     = next_id_q;
		out_load      = 1'b0;
		out_d         = '0;
		ctl           = '0;
		ctl.wr_idx    = free_idx;
		ctl.wr_data.id        = next_id_q;
		ctl.wr_data.client    = cmd_q.client_key;
		ctl.wr_data.kind_mask = cmd_q.filter_kind_mask;
		ctl.wr_data.sev_floor = cmd_q.filter_sev_floor;
		ctl.wr_data.source    = cmd_q.filter_source;
		ctl.rd_idx    = rd_idx_q[esft_pkg::SlotIdxW-1:0];
		ctl.clr_idx   = idx_s1;

		unique case (state_q)
			esft_pkg::S_IDLE: begin
				rd_idx_d = '0;
				v_s1_d   = 1'b0;
				hold_v_d = 1'b0;
				n_d      = '0;
				if (cmd.valid) begin
					unique case (cmd.payload.opcode) inside
						esft_pkg::OP_SUBSCRIBE: state_d = esft_pkg::S_SUB;
						esft_pkg::OP_UNSUBSCRIBE,
						esft_pkg::OP_EVENT: state_d = esft_pkg::S_SCAN;
						default: state_d = esft_pkg::S_IDLE;
					endcase
				end
			end
			esft_pkg::S_SUB: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_d.last = 1'b1;
					if (free_any) begin
						ctl.wr_en       = 1'b1;
						out_d.status    = esft_pkg::ST_OK;
						out_d.result_id = next_id_q;
						next_id_d       = next_id_q + 32'd1;
					end else begin
						out_d.status = esft_pkg::ST_FULL;
					end
					state_d = esft_pkg::S_IDLE;
				end
			end
			esft_pkg::S_SCAN: begin
				if (!v_s1 && issue_done) begin
					if (out_free) begin
						out_load   = 1'b1;
						out_d.last = 1'b1;
						if (!is_event) begin
							out_d.status = esft_pkg::ST_NOTFOUND;
						end else if (hold_v_q) begin
							out_d.status       = esft_pkg::ST_OK;
							out_d.result_id    = hold_id_q;
							out_d.match_client = hold_client_q;
							out_d.matched      = 1'b1;
						end else begin
							out_d.status = esft_pkg::ST_OK;
						end
						state_d = esft_pkg::S_IDLE;
					end
				end else begin
					logic consume;
					consume = 1'b1;
					if (is_event) begin
						if (pass) begin
							if (hold_v_q && !out_free) begin
								consume = 1'b0;
							end else begin
								if (hold_v_q) begin
									out_load           = 1'b1;
									out_d.status       = esft_pkg::ST_OK;
									out_d.result_id    = hold_id_q;
									out_d.match_client = hold_client_q;
									out_d.matched      = 1'b1;
								end
								hold_v_d      = 1'b1;
								hold_id_d     = rd_entry.id;
								hold_client_d = rd_entry.client;
								n_d           = n_q + esft_pkg::ResCntW'(1);
							end
						end
					end else if (hit) begin
						consume = 1'b0;
						if (out_free) begin
							out_load     = 1'b1;
							out_d.status = esft_pkg::ST_OK;
							out_d.last   = 1'b1;
							ctl.clr_en   = 1'b1;
							state_d      = esft_pkg::S_IDLE;
						end
					end
					if (consume) begin
						if (!issue_done) begin
							ctl.rd_en = 1'b1;
							rd_idx_d  = rd_idx_q + esft_pkg::SlotCntW'(1);
							v_s1_d    = 1'b1;
						end else begin
							v_s1_d = 1'b0;
						end
					end
				end
			end
			default: state_d = esft_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= esft_pkg::S_IDLE;
			rd_idx_q  <= '0;
			v_s1      <= 1'b0;
			hold_v_q  <= 1'b0;
			n_q       <= '0;
			next_id_q <= esft_pkg::ID_START;
			out_v_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_idx_q  <= rd_idx_d;
			v_s1      <= v_s1_d;
			hold_v_q  <= hold_v_d;
			n_q       <= n_d;
			next_id_q <= next_id_d;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q <= cmd.payload;
		end
		if (ctl.rd_en) begin
			idx_s1 <= ctl.rd_idx;
		end
		hold_id_q     <= hold_id_d;
		hold_client_q <= hold_client_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

endmodule

FILE: bench/esft_result_checker.sv
// Result checker for the event subscription filter table: predicts result items and compares them.
module esft_result_checker (
	input  logic clk,
	input  logic arst_n,
	esft_cmd_if  cmd,
	esft_res_if  res,
	output int   mismatches,
	output int   pending
);

	logic [esft_pkg::SLOTS-1:0] sub_live;
	esft_pkg::slot_entry_t      sub_tab [esft_pkg::SLOTS];
	logic [31:0]                id_next;
	esft_pkg::res_t             expected_q [$];
	int                         err_cnt = 0;

	assign mismatches = err_cnt;

	function automatic esft_pkg::res_t mk_res(logic [1:0] st, logic [31:0] rid,
			logic [31:0] cl, logic hit, logic fin);
		esft_pkg::res_t r;
		r.status       = st;
		r.result_id    = rid;
		r.match_client = cl;
		r.matched      = hit;
		r.last         = fin;
		return r;
	endfunction

	function automatic string fmt_res(esft_pkg::res_t r);
		return $sformatf("status=%0d id=%h client=%h matched=%b last=%b",
			r.status, r.result_id, r.match_client, r.matched, r.last);
	endfunction

	function automatic logic filter_passes(esft_pkg::slot_entry_t e, esft_pkg::cmd_t c);
		return (e.kind_mask[c.event_kind] || e.kind_mask == esft_pkg::ALL_KINDS) &&
			c.event_severity >= e.sev_floor &&
			(e.source == '0 || e.source == c.event_source);
	endfunction

	function automatic void predict_results(esft_pkg::cmd_t c);
		int idx;
		int hit_idx [$];
		idx = -1;
		case (c.opcode)
			esft_pkg::OP_SUBSCRIBE: begin
				for (int i = 0; i < esft_pkg::SLOTS; i++)
					if (idx < 0 && !sub_live[i])
						idx = i;
				if (idx >= 0) begin
					sub_live[idx]           = 1'b1;
					sub_tab[idx].id         = id_next;
					sub_tab[idx].client     = c.client_key;
					sub_tab[idx].kind_mask  = c.filter_kind_mask;
					sub_tab[idx].sev_floor  = c.filter_sev_floor;
					sub_tab[idx].source     = c.filter_source;
					expected_q.push_back(mk_res(esft_pkg::ST_OK, id_next, '0, 1'b0, 1'b1));
					id_next = id_next + 32'd1;
				end else begin
					expected_q.push_back(mk_res(esft_pkg::ST_FULL, '0, '0, 1'b0, 1'b1));
				end
			end
			esft_pkg::OP_UNSUBSCRIBE: begin
				for (int i = 0; i < esft_pkg::SLOTS; i++)
					if (idx < 0 && sub_live[i] && sub_tab[i].id == c.target_id)
						idx = i;
				if (idx >= 0) begin
					sub_live[idx] = 1'b0;
					expected_q.push_back(mk_res(esft_pkg::ST_OK, '0, '0, 1'b0, 1'b1));
				end else begin
					expected_q.push_back(mk_res(esft_pkg::ST_NOTFOUND, '0, '0, 1'b0, 1'b1));
				end
			end
			esft_pkg::OP_EVENT: begin
				for (int i = 0; i < esft_pkg::SLOTS; i++)
					if (sub_live[i] && hit_idx.size() < esft_pkg::MAX_RESULTS &&
							filter_passes(sub_tab[i], c))
						hit_idx.push_back(i);
				if (hit_idx.size() == 0)
					expected_q.push_back(mk_res(esft_pkg::ST_OK, '0, '0, 1'b0, 1'b1));
				for (int k = 0; k < hit_idx.size(); k++)
					expected_q.push_back(mk_res(esft_pkg::ST_OK, sub_tab[hit_idx[k]].id,
						sub_tab[hit_idx[k]].client, 1'b1, k == hit_idx.size() - 1));
			end
			default: ;
		endcase
	endfunction

	function automatic void check_result(esft_pkg::res_t got);
		esft_pkg::res_t want;
		if (expected_q.size() == 0) begin
			if (err_cnt < 10)
				$display("%0t: unexpected result item: %s", $time, fmt_res(got));
			err_cnt++;
			return;
		end
		want = expected_q.pop_front();
		if (got.status !== want.status || got.result_id !== want.result_id ||
				got.match_client !== want.match_client || got.matched !== want.matched ||
				got.last !== want.last) begin
			if (err_cnt < 10)
				$display("%0t: result mismatch: expected %s, got %s", $time,
					fmt_res(want), fmt_res(got));
			err_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_live = '0;
			id_next  = esft_pkg::ID_START;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (res.valid && res.ready)
				check_result(res.payload);
			if (cmd.valid && cmd.ready)
				predict_results(cmd.payload);
			pending <= expected_q.size();
		end
	end

endmodule

FILE: bench/testbench.sv
// Bench top for the event subscription filter table: clock, reset, stimulus, watchdog, verdict.
module testbench;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 64;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   pending;
	int   gap_pct     = 0;
	int   stall_pct   = 0;
	int   idle_cycles = 0;
	int   subs_sent   = 0;

	esft_cmd_if cmd_ch ();
	esft_res_if res_ch ();

	event_subscription_filter_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	esft_result_checker result_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.res        (res_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	function automatic esft_pkg::cmd_t noise_cmd();
		esft_pkg::cmd_t c;
		c.opcode           = 2'($urandom_range(0, 3));
		c.client_key       = $urandom;
		c.filter_kind_mask = $urandom;
		c.filter_sev_floor = 8'($urandom);
		c.filter_source    = $urandom;
		c.target_id        = $urandom;
		c.event_kind       = 5'($urandom);
		c.event_severity   = 8'($urandom);
		c.event_source     = $urandom;
		return c;
	endfunction

	function automatic esft_pkg::cmd_t mk_sub(logic [31:0] client, logic [31:0] mask,
			logic [7:0] sev, logic [31:0] src);
		esft_pkg::cmd_t c;
		c = noise_cmd();
		c.opcode           = esft_pkg::OP_SUBSCRIBE;
		c.client_key       = client;
		c.filter_kind_mask = mask;
		c.filter_sev_floor = sev;
		c.filter_source    = src;
		return c;
	endfunction

	function automatic esft_pkg::cmd_t mk_unsub(logic [31:0] target);
		esft_pkg::cmd_t c;
		c = noise_cmd();
		c.opcode    = esft_pkg::OP_UNSUBSCRIBE;
		c.target_id = target;
		return c;
	endfunction

	function automatic esft_pkg::cmd_t mk_event(logic [4:0] kind, logic [7:0] sev,
			logic [31:0] src);
		esft_pkg::cmd_t c;
		c = noise_cmd();
		c.opcode         = esft_pkg::OP_EVENT;
		c.event_kind     = kind;
		c.event_severity = sev;
		c.event_source   = src;
		return c;
	endfunction

	function automatic esft_pkg::cmd_t mk_unused();
		esft_pkg::cmd_t c;
		c = noise_cmd();
		c.opcode = OP_UNUSED;
		return c;
	endfunction

	function automatic esft_pkg::cmd_t rand_item();
		esft_pkg::cmd_t c;
		int   pick;
		int   sel;
		c    = noise_cmd();
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			c.opcode = esft_pkg::OP_SUBSCRIBE;
			sel = $urandom_range(0, 3);
			if (sel == 0)
				c.filter_kind_mask = esft_pkg::ALL_KINDS;
			else if (sel > 1)
				c.filter_kind_mask = (32'd1 << $urandom_range(0, 31)) |
					(32'd1 << $urandom_range(0, 31));
			if ($urandom_range(0, 9) < 7)
				c.filter_sev_floor = 8'($urandom_range(0, 100));
			sel = $urandom_range(0, 19);
			if (sel < 10)
				c.filter_source = '0;
			else if (sel < 17)
				c.filter_source = $urandom_range(1, 4);
		end else if (pick < 55) begin
			c.opcode = esft_pkg::OP_UNSUBSCRIBE;
			if ($urandom_range(0, 4) != 0)
				c.target_id = $urandom_range(1, subs_sent + 1);
		end else if (pick < 95) begin
			c.opcode = esft_pkg::OP_EVENT;
			if ($urandom_range(0, 4) != 0)
				c.event_source = $urandom_range(1, 4);
		end else begin
			c.opcode = OP_UNUSED;
		end
		return c;
	endfunction

	task automatic send_item(input esft_pkg::cmd_t c);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.payload <= c;
		if (c.opcode == esft_pkg::OP_SUBSCRIBE)
			subs_sent++;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		cmd_ch.valid   <= 1'b0;
		cmd_ch.payload <= '0;
		gap_pct   = 20;
		stall_pct = 15;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(mk_event(5'd0, 8'd0, 32'd0));
		send_item(mk_unsub(32'd1));
		send_item(mk_unused());
		send_item(mk_sub(32'hFFFF_FFFF, esft_pkg::ALL_KINDS, 8'd0, 32'd0));
		send_item(mk_sub(32'd0, 32'h8000_0000, 8'd255, 32'hFFFF_FFFF));
		send_item(mk_sub(32'h0000_1234, 32'h0000_0001, 8'd128, 32'd0));
		send_item(mk_event(5'd31, 8'd255, 32'hFFFF_FFFF));
		send_item(mk_event(5'd0, 8'd128, 32'd7));
		send_item(mk_event(5'd0, 8'd127, 32'd7));
		send_item(mk_event(5'd31, 8'd255, 32'hFFFF_FFFE));
		send_item(mk_unsub(32'd1));
		send_item(mk_event(5'd5, 8'd0, 32'd0));
		send_item(mk_unsub(32'd1));
		send_item(mk_sub(32'h0000_AAAA, 32'd0, 8'd0, 32'd0));
		send_item(mk_event(5'd0, 8'd255, 32'd3));
		send_item(mk_unsub(32'hFFFF_FFFF));
		send_item(mk_unsub(32'd2));
		send_item(mk_unsub(32'd3));
		send_item(mk_unsub(32'd4));
		send_item(mk_unused());
		wait_drained();

		repeat (esft_pkg::SLOTS + 1)
			send_item(mk_sub($urandom, esft_pkg::ALL_KINDS, 8'd0, 32'd0));
		send_item(mk_event(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)), $urandom));
		send_item(mk_event(5'($urandom_range(0, 31)), 8'd0, 32'd0));

		for (int n = 0; n < 110; n++) begin
			gap_pct   = (n >= 40 && n < 60) ? 0 : 25;
			stall_pct = (n >= 40 && n < 60) ? 0 : 15;
			send_item(rand_item());
		end
		wait_drained();

		gap_pct   = 0;
		stall_pct = 0;
		repeat (30)
			send_item(rand_item());
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
